// ----- src/aabbdc_pkg.sv -----
// ----------------------------------------------------------------------------
// aabbdc_pkg
// Shared widths and payload types for the box separation unit.
// ----------------------------------------------------------------------------
package aabbdc_pkg;

  localparam int unsigned COORD_BITS = 24;  // signed Q11.12 coordinate
  localparam int unsigned AXES       = 3;   // active axes, 1 to 3
  localparam int unsigned AXIS_SLOTS = 3;   // x, y, z ports
  localparam int unsigned ROOT_W     = 25;  // separation width
  localparam int unsigned SQ_W       = 2 * ROOT_W;  // squared separation width

  localparam logic [SQ_W-1:0] SQ_MAX = '1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [AXIS_SLOTS-1:0][COORD_BITS-1:0] wit_t;

  // State carried from one root cell to the next
  typedef struct packed {
    logic [SQ_W-1:0]   rad;   // radicand bits not yet consumed, msb first
    logic [SQ_W-1:0]   sq;    // squared separation, passed through
    logic [ROOT_W:0]   rem;   // partial remainder
    logic [ROOT_W-1:0] root;  // partial root
    wit_t              wa;
    wit_t              wb;
  } root_t;

endpackage

// ----- src/aabb_distance_closest_points_unit.sv -----
// ----------------------------------------------------------------------------
// aabb_distance_closest_points_unit
// Separation and witness points of two axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one box pair: min and
//   max corners of A and B, signed Q11.12. Output channel (out_valid_o /
//   out_ready_i) returns the floored root of the squared gap sum (Q.12),
//   the squared sum itself (Q.24) and the witness point on each box.
//   Throughput: one request per cycle while the skid entry is free. From
//   acceptance to out_valid_o: two stages of per-axis compare and square,
//   one stage of saturating sum, a chain of 25 root cells (one root bit
//   each) and the output register.
//   A one-entry skid buffer sits behind the output register; the pipeline
//   and in_ready_o hold only once the skid entry is occupied, so a
//   stalled receiver costs nothing until two results are waiting.
//   Reset clears all valid flags; no request is in flight afterwards and
//   the block accepts a request in the first cycle after reset.
//   Axes at or beyond AXES report zero witnesses and add no gap.
// ----------------------------------------------------------------------------
module aabb_distance_closest_points_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  aabbdc_pkg::coord_t            a_min_x_i,
  input  aabbdc_pkg::coord_t            a_min_y_i,
  input  aabbdc_pkg::coord_t            a_min_z_i,
  input  aabbdc_pkg::coord_t            a_max_x_i,
  input  aabbdc_pkg::coord_t            a_max_y_i,
  input  aabbdc_pkg::coord_t            a_max_z_i,
  input  aabbdc_pkg::coord_t            b_min_x_i,
  input  aabbdc_pkg::coord_t            b_min_y_i,
  input  aabbdc_pkg::coord_t            b_min_z_i,
  input  aabbdc_pkg::coord_t            b_max_x_i,
  input  aabbdc_pkg::coord_t            b_max_y_i,
  input  aabbdc_pkg::coord_t            b_max_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [aabbdc_pkg::ROOT_W-1:0] separation_o,
  output logic [aabbdc_pkg::SQ_W-1:0]   squared_separation_o,
  output aabbdc_pkg::coord_t            witness_a_x_o,
  output aabbdc_pkg::coord_t            witness_a_y_o,
  output aabbdc_pkg::coord_t            witness_a_z_o,
  output aabbdc_pkg::coord_t            witness_b_x_o,
  output aabbdc_pkg::coord_t            witness_b_y_o,
  output aabbdc_pkg::coord_t            witness_b_z_o
);
  import aabbdc_pkg::*;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   sq;
    wit_t              wa;
    wit_t              wb;
  } res_t;

  coord_t          a_min [AXIS_SLOTS];
  coord_t          a_max [AXIS_SLOTS];
  coord_t          b_min [AXIS_SLOTS];
  coord_t          b_max [AXIS_SLOTS];
  logic [SQ_W-1:0] sq    [AXIS_SLOTS];
  wit_t            wa, wb;

  logic            en;
  logic            v1_q, v2_q;
  logic [SQ_W+1:0] total;
  root_t           sum_d, sum_q;
  logic            sum_vld_q;

  logic            cell_vld [ROOT_W+1];
  root_t           cell_dat [ROOT_W+1];

  res_t            pipe_res, out_d, out_q, skid_q;
  logic            out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic            take, pipe_push;

  assign a_min = '{a_min_x_i, a_min_y_i, a_min_z_i};
  assign a_max = '{a_max_x_i, a_max_y_i, a_max_z_i};
  assign b_min = '{b_min_x_i, b_min_y_i, b_min_z_i};
  assign b_max = '{b_max_x_i, b_max_y_i, b_max_z_i};

  // Whole pipeline advances while the skid entry is free
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  for (genvar g = 0; g < AXIS_SLOTS; g++) begin : g_axis
    if (g < AXES) begin : g_on
      aabbdc_axis_cell u_axis (
        .clk_i   (clk_i),
        .en_i    (en),
        .a_min_i (a_min[g]),
        .a_max_i (a_max[g]),
        .b_min_i (b_min[g]),
        .b_max_i (b_max[g]),
        .sq_o    (sq[g]),
        .wa_o    (wa[g]),
        .wb_o    (wb[g])
      );
    end else begin : g_off
      assign sq[g] = '0;
      assign wa[g] = '0;
      assign wb[g] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      sum_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= in_valid_i;
      v2_q      <= v1_q;
      sum_vld_q <= v2_q;
    end
  end

  // Saturating sum of the squared gaps
  assign total = (SQ_W+2)'(sq[0]) + (SQ_W+2)'(sq[1]) + (SQ_W+2)'(sq[2]);

  always_comb begin
    sum_d.sq   = (total > (SQ_W+2)'(SQ_MAX)) ? SQ_MAX : total[SQ_W-1:0];
    sum_d.rad  = sum_d.sq;
    sum_d.rem  = '0;
    sum_d.root = '0;
    sum_d.wa   = wa;
    sum_d.wb   = wb;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q <= sum_d;
    end
  end

  assign cell_vld[0] = sum_vld_q;
  assign cell_dat[0] = sum_q;

  for (genvar c = 0; c < ROOT_W; c++) begin : g_root
    aabbdc_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cell_vld[c]),
      .data_i  (cell_dat[c]),
      .valid_o (cell_vld[c+1]),
      .data_o  (cell_dat[c+1])
    );
  end

  assign pipe_res.root = cell_dat[ROOT_W].root;
  assign pipe_res.sq   = cell_dat[ROOT_W].sq;
  assign pipe_res.wa   = cell_dat[ROOT_W].wa;
  assign pipe_res.wb   = cell_dat[ROOT_W].wb;

  assign take      = out_ready_i || !out_valid_q;
  assign pipe_push = en && cell_vld[ROOT_W];

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = pipe_res;
        out_valid_d = pipe_push;
      end
    end else if (pipe_push) begin
      // receiver stalled: park the result
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (!take && pipe_push) begin
      skid_q <= pipe_res;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign separation_o         = out_q.root;
  assign squared_separation_o = out_q.sq;
  assign witness_a_x_o        = out_q.wa[0];
  assign witness_a_y_o        = out_q.wa[1];
  assign witness_a_z_o        = out_q.wa[2];
  assign witness_b_x_o        = out_q.wb[0];
  assign witness_b_y_o        = out_q.wb[1];
  assign witness_b_z_o        = out_q.wb[2];

  // Assertions
  logic [SQ_W+1:0] root_sq, root_next_sq;
  assign root_sq      = (SQ_W+2)'(out_q.root) * (SQ_W+2)'(out_q.root);
  assign root_next_sq = ((SQ_W+2)'(out_q.root) + 1'b1) * ((SQ_W+2)'(out_q.root) + 1'b1);

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry occupied while output register is empty");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_ready_i |=> !skid_valid_q)
    else $error("skid entry not drained after output handshake");

  a_root_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> root_sq <= (SQ_W+2)'(out_q.sq))
    else $error("separation squared exceeds squared separation");

  a_root_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> root_next_sq > (SQ_W+2)'(out_q.sq))
    else $error("separation is not the floored root");

  a_ready_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_q) && !$past(out_ready_i))
    else $error("input stalled without an output stall");

endmodule

// ----- src/aabbdc_axis_cell.sv -----
// ----------------------------------------------------------------------------
// aabbdc_axis_cell
// One axis: interval test, witness selection, squared gap (two stages).
// ----------------------------------------------------------------------------
module aabbdc_axis_cell (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  aabbdc_pkg::coord_t            a_min_i,
  input  aabbdc_pkg::coord_t            a_max_i,
  input  aabbdc_pkg::coord_t            b_min_i,
  input  aabbdc_pkg::coord_t            b_max_i,
  output logic [aabbdc_pkg::SQ_W-1:0]   sq_o,
  output aabbdc_pkg::coord_t            wa_o,
  output aabbdc_pkg::coord_t            wb_o
);
  import aabbdc_pkg::*;

  logic signed [COORD_BITS:0] diff_ab, diff_ba, mid_sum;
  logic [COORD_BITS-1:0]      gap_d, gap_q;
  coord_t                     wa_d, wb_d, wa1_q, wb1_q, wa2_q, wb2_q;
  logic [2*COORD_BITS-1:0]    prod;
  logic [SQ_W-1:0]            sq_d, sq_q;

  assign diff_ab = {a_min_i[COORD_BITS-1], a_min_i} - {b_max_i[COORD_BITS-1], b_max_i};
  assign diff_ba = {b_min_i[COORD_BITS-1], b_min_i} - {a_max_i[COORD_BITS-1], a_max_i};

  always_comb begin
    gap_d   = '0;
    mid_sum = '0;
    if (a_min_i > b_max_i) begin
      gap_d = diff_ab[COORD_BITS-1:0];
      wa_d  = a_min_i;
      wb_d  = b_max_i;
    end else if (b_min_i > a_max_i) begin
      gap_d = diff_ba[COORD_BITS-1:0];
      wa_d  = a_max_i;
      wb_d  = b_min_i;
    end else begin
      // overlap: both witnesses at the floored midpoint
      if (b_min_i >= a_min_i) begin
        mid_sum = {a_max_i[COORD_BITS-1], a_max_i} + {b_min_i[COORD_BITS-1], b_min_i};
      end else begin
        mid_sum = {a_min_i[COORD_BITS-1], a_min_i} + {b_max_i[COORD_BITS-1], b_max_i};
      end
      wa_d = mid_sum[COORD_BITS:1];
      wb_d = mid_sum[COORD_BITS:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gap_q <= gap_d;
      wa1_q <= wa_d;
      wb1_q <= wb_d;
    end
  end

  assign prod = gap_q * gap_q;

  // gaps wider than the root saturate the square
  always_comb begin
    if (|(gap_q >> ROOT_W)) begin
      sq_d = SQ_MAX;
    end else begin
      sq_d = SQ_W'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      wa2_q <= wa1_q;
      wb2_q <= wb1_q;
    end
  end

  assign sq_o = sq_q;
  assign wa_o = wa2_q;
  assign wb_o = wb2_q;

endmodule

// ----- src/aabbdc_root_cell.sv -----
// ----------------------------------------------------------------------------
// aabbdc_root_cell
// One root bit per cell: shift in two radicand bits, trial subtract.
// ----------------------------------------------------------------------------
module aabbdc_root_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  aabbdc_pkg::root_t data_i,
  output logic              valid_o,
  output aabbdc_pkg::root_t data_o
);
  import aabbdc_pkg::*;

  logic [ROOT_W+2:0] rem_wide, trial, rem_sub;
  logic              take_bit;
  logic              valid_q;
  root_t             data_d, data_q;

  assign rem_wide = {data_i.rem, data_i.rad[SQ_W-1 -: 2]};
  assign trial    = {1'b0, data_i.root, 2'b01};
  assign take_bit = rem_wide >= trial;
  assign rem_sub  = rem_wide - trial;

  always_comb begin
    data_d      = data_i;
    data_d.rad  = {data_i.rad[SQ_W-3:0], 2'b00};
    data_d.root = {data_i.root[ROOT_W-2:0], take_bit};
    data_d.rem  = take_bit ? rem_sub[ROOT_W:0] : rem_wide[ROOT_W:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for aabb_distance_closest_points_unit. Drives box pairs through
// the request channel with random gaps and collects results with random
// stalls. One long receiver hold-off backs the pipeline up into the request
// side. Every result is checked field by field against an in-order
// prediction of the gap sum, its floored root and the witness points.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aabbdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned HOLD_AFTER   = 200;  // results seen before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;

  localparam longint unsigned SQ_SAT    = (64'd1 << SQ_W) - 64'd1;
  localparam longint unsigned GAP_LIMIT = (64'd1 << ROOT_W) - 64'd1;

  localparam coord_t C_MIN = 24'sh800000;
  localparam coord_t C_MAX = 24'sh7fffff;

  typedef struct packed {
    logic [AXIS_SLOTS-1:0][COORD_BITS-1:0] a_lo;
    logic [AXIS_SLOTS-1:0][COORD_BITS-1:0] a_hi;
    logic [AXIS_SLOTS-1:0][COORD_BITS-1:0] b_lo;
    logic [AXIS_SLOTS-1:0][COORD_BITS-1:0] b_hi;
  } box_pair_t;

  typedef struct packed {
    logic [ROOT_W-1:0]                     sep;
    logic [SQ_W-1:0]                       dist_sq;
    logic [AXIS_SLOTS-1:0][COORD_BITS-1:0] near_a;
    logic [AXIS_SLOTS-1:0][COORD_BITS-1:0] near_b;
  } separation_t;

  class box_gap_ledger;
    separation_t expected_gaps[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function logic [ROOT_W-1:0] floor_root(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r[ROOT_W-1:0];
    endfunction

    function separation_t predict_separation(box_pair_t p);
      separation_t     r;
      longint          lo_a, hi_a, lo_b, hi_b, pa, pb;
      longint unsigned gap, acc;
      r   = '0;
      acc = 0;
      for (int ax = 0; ax < AXES; ax++) begin
        lo_a = longint'($signed(p.a_lo[ax]));
        hi_a = longint'($signed(p.a_hi[ax]));
        lo_b = longint'($signed(p.b_lo[ax]));
        hi_b = longint'($signed(p.b_hi[ax]));
        gap  = 0;
        if (lo_a > hi_b) begin
          gap = lo_a - hi_b;
          pa  = lo_a;
          pb  = hi_b;
        end else if (lo_b > hi_a) begin
          gap = lo_b - hi_a;
          pa  = hi_a;
          pb  = lo_b;
        end else begin
          // overlap: both witnesses sit on the floored midpoint
          pa = (lo_b >= lo_a) ? (hi_a + lo_b) >>> 1 : (lo_a + hi_b) >>> 1;
          pb = pa;
        end
        acc += (gap > GAP_LIMIT) ? SQ_SAT : gap * gap;
        if (acc > SQ_SAT) acc = SQ_SAT;
        r.near_a[ax] = pa[COORD_BITS-1:0];
        r.near_b[ax] = pb[COORD_BITS-1:0];
      end
      r.dist_sq = acc[SQ_W-1:0];
      r.sep     = floor_root(acc);
      return r;
    endfunction

    function void log_request(box_pair_t p);
      expected_gaps.push_back(predict_separation(p));
    endfunction

    function int unsigned pending();
      return expected_gaps.size();
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("MISMATCH result %0d: %s", checked, msg);
    endfunction

    function void check_result(separation_t got);
      separation_t want;
      if (expected_gaps.size() == 0) begin
        fail("result with no request pending");
        checked++;
        return;
      end
      want = expected_gaps.pop_front();
      if (got.sep !== want.sep)
        fail($sformatf("separation expected %0d, got %0d", want.sep, got.sep));
      if (got.dist_sq !== want.dist_sq)
        fail($sformatf("squared_separation expected %0d, got %0d",
                       want.dist_sq, got.dist_sq));
      for (int ax = 0; ax < AXIS_SLOTS; ax++) begin
        if (got.near_a[ax] !== want.near_a[ax])
          fail($sformatf("witness_a axis %0d expected %0d, got %0d", ax,
                         $signed(want.near_a[ax]), $signed(got.near_a[ax])));
        if (got.near_b[ax] !== want.near_b[ax])
          fail($sformatf("witness_b axis %0d expected %0d, got %0d", ax,
                         $signed(want.near_b[ax]), $signed(got.near_b[ax])));
      end
      checked++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready_o;
  box_pair_t   req       = '0;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  separation_t seen;

  box_gap_ledger ledger = new();

  aabb_distance_closest_points_unit uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .a_min_x_i           (req.a_lo[0]),
    .a_min_y_i           (req.a_lo[1]),
    .a_min_z_i           (req.a_lo[2]),
    .a_max_x_i           (req.a_hi[0]),
    .a_max_y_i           (req.a_hi[1]),
    .a_max_z_i           (req.a_hi[2]),
    .b_min_x_i           (req.b_lo[0]),
    .b_min_y_i           (req.b_lo[1]),
    .b_min_z_i           (req.b_lo[2]),
    .b_max_x_i           (req.b_hi[0]),
    .b_max_y_i           (req.b_hi[1]),
    .b_max_z_i           (req.b_hi[2]),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .separation_o        (seen.sep),
    .squared_separation_o(seen.dist_sq),
    .witness_a_x_o       (seen.near_a[0]),
    .witness_a_y_o       (seen.near_a[1]),
    .witness_a_z_o       (seen.near_a[2]),
    .witness_b_x_o       (seen.near_b[0]),
    .witness_b_y_o       (seen.near_b[1]),
    .witness_b_z_o       (seen.near_b[2])
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned idle_span(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic box_pair_t uniform_pair(coord_t la, coord_t ha, coord_t lb, coord_t hb);
    box_pair_t p;
    for (int ax = 0; ax < AXIS_SLOTS; ax++) begin
      p.a_lo[ax] = la;
      p.a_hi[ax] = ha;
      p.b_lo[ax] = lb;
      p.b_hi[ax] = hb;
    end
    return p;
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t   p;
    longint      v[4];
    longint      s[4];
    longint      t, center;
    int unsigned spread, shape;
    for (int ax = 0; ax < AXIS_SLOTS; ax++) begin
      case ($urandom_range(0, 3))
        0:       spread = 0;      // full range
        1:       spread = 65536;
        default: spread = 8;      // ties and touching faces
      endcase
      center = longint'($urandom_range(0, 16777215 - 2 * spread)) - 8388608 + spread;
      for (int k = 0; k < 4; k++) begin
        if (spread == 0) v[k] = longint'($signed(COORD_BITS'($urandom())));
        else v[k] = center + longint'($urandom_range(0, 2 * spread)) - spread;
        s[k] = v[k];
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3 - i; j++)
          if (s[j] > s[j+1]) begin
            t      = s[j];
            s[j]   = s[j+1];
            s[j+1] = t;
          end
      shape = $urandom_range(0, 11);
      case (shape)
        0, 1: begin  // A above B
          p.b_lo[ax] = s[0][COORD_BITS-1:0]; p.b_hi[ax] = s[1][COORD_BITS-1:0];
          p.a_lo[ax] = s[2][COORD_BITS-1:0]; p.a_hi[ax] = s[3][COORD_BITS-1:0];
        end
        2, 3: begin  // B above A
          p.a_lo[ax] = s[0][COORD_BITS-1:0]; p.a_hi[ax] = s[1][COORD_BITS-1:0];
          p.b_lo[ax] = s[2][COORD_BITS-1:0]; p.b_hi[ax] = s[3][COORD_BITS-1:0];
        end
        4, 5: begin
          p.a_lo[ax] = s[0][COORD_BITS-1:0]; p.a_hi[ax] = s[2][COORD_BITS-1:0];
          p.b_lo[ax] = s[1][COORD_BITS-1:0]; p.b_hi[ax] = s[3][COORD_BITS-1:0];
        end
        6, 7: begin
          p.b_lo[ax] = s[0][COORD_BITS-1:0]; p.b_hi[ax] = s[2][COORD_BITS-1:0];
          p.a_lo[ax] = s[1][COORD_BITS-1:0]; p.a_hi[ax] = s[3][COORD_BITS-1:0];
        end
        8, 9: begin  // B inside A
          p.a_lo[ax] = s[0][COORD_BITS-1:0]; p.a_hi[ax] = s[3][COORD_BITS-1:0];
          p.b_lo[ax] = s[1][COORD_BITS-1:0]; p.b_hi[ax] = s[2][COORD_BITS-1:0];
        end
        10: begin    // A inside B
          p.b_lo[ax] = s[0][COORD_BITS-1:0]; p.b_hi[ax] = s[3][COORD_BITS-1:0];
          p.a_lo[ax] = s[1][COORD_BITS-1:0]; p.a_hi[ax] = s[2][COORD_BITS-1:0];
        end
        default: begin  // unsorted corners, inverted boxes included
          p.a_lo[ax] = v[0][COORD_BITS-1:0]; p.a_hi[ax] = v[1][COORD_BITS-1:0];
          p.b_lo[ax] = v[2][COORD_BITS-1:0]; p.b_hi[ax] = v[3][COORD_BITS-1:0];
        end
      endcase
    end
    return p;
  endfunction

  task automatic send_request(box_pair_t p, bit quiet);
    int unsigned gap;
    gap = idle_span(quiet);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req      <= p;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    ledger.log_request(p);
  endtask

  task automatic run_directed();
    box_pair_t p;
    send_request(uniform_pair('0, '0, '0, '0), 1'b0);
    send_request(uniform_pair(-1, 1, -1, 1), 1'b0);
    send_request(uniform_pair(100, 200, -50, 50), 1'b0);
    send_request(uniform_pair(-300, -200, 400, 500), 1'b0);
    send_request(uniform_pair(10, 20, 20, 30), 1'b0);       // touching faces
    send_request(uniform_pair(0, 9, 10, 20), 1'b0);         // gap of one lsb
    send_request(uniform_pair(5, 30, 0, 10), 1'b0);
    send_request(uniform_pair(-4, -1, -2, 3), 1'b0);        // odd negative midpoint
    send_request(uniform_pair(-3, 6, -8, -3), 1'b0);
    send_request(uniform_pair(C_MAX, C_MAX, C_MIN, C_MIN), 1'b0);  // widest gap
    send_request(uniform_pair(C_MIN, C_MIN, C_MAX, C_MAX), 1'b0);
    send_request(uniform_pair(C_MAX, C_MAX, C_MAX, C_MAX), 1'b0);
    send_request(uniform_pair(C_MIN, C_MIN, C_MIN, C_MIN), 1'b0);
    send_request(uniform_pair(C_MIN, C_MAX, C_MIN, C_MAX), 1'b0);
    send_request(uniform_pair(C_MIN, C_MAX, -5, 5), 1'b0);
    send_request(uniform_pair(-5, 5, C_MIN, C_MAX), 1'b0);
    send_request(uniform_pair(100, -100, 0, 0), 1'b0);      // inverted box A
    send_request(uniform_pair(50, -50, 40, -40), 1'b0);     // both inverted
    send_request(uniform_pair(0, 0, 4096, 8192), 1'b0);     // one unit per axis
    // separated one way on x, the other way on y, overlapping on z
    p = uniform_pair(-7, 7, -3, 11);
    p.a_lo[0] = 24'sd9000;  p.a_hi[0] = 24'sd9100;
    p.b_lo[0] = -24'sd200;  p.b_hi[0] = 24'sd100;
    p.a_lo[1] = C_MIN;      p.a_hi[1] = -24'sd1;
    p.b_lo[1] = 24'sd1;     p.b_hi[1] = C_MAX;
    send_request(p, 1'b0);
    p = uniform_pair(C_MIN, C_MIN, C_MAX, C_MAX);
    p.a_lo[2] = 24'sd12;    p.a_hi[2] = 24'sd12;
    p.b_lo[2] = 24'sd12;    p.b_hi[2] = 24'sd12;
    send_request(p, 1'b0);
  endtask

  initial begin : stimulus
    bit quiet;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    run_directed();
    for (int blk = 0; blk < 22; blk++) begin
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 50; k++) send_request(random_pair(), quiet);
    end
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : collect
    int unsigned results;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned seg_left;
    bit          quiet;
    bit          held;
    logic        next_ready;
    results    = 0;
    stall_left = 0;
    hold_left  = 0;
    seg_left   = 0;
    quiet      = 1'b0;
    held       = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        ledger.check_result(seen);
        results++;
        // back the pipeline up into the request side once
        if (results == HOLD_AFTER && !held) begin
          held      = 1'b1;
          hold_left = HOLD_CYCLES;
        end
      end
      if (seg_left == 0) begin
        seg_left = 150;
        quiet    = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < 30) begin
        stall_left = idle_span(1'b0);
        next_ready = (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end else begin
        next_ready = 1'b1;
      end
      out_ready <= next_ready;
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
